@@ src/ipv_pkg.sv @@
// Package for the address text validator: character codes, limits,
// the checker state record and the verdict codes.
// No dependencies.
`default_nettype none

package ipv_pkg;

  // Character codes of interest.
  localparam logic [7:0] ChDot   = 8'h2e;
  localparam logic [7:0] ChColon = 8'h3a;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChNine  = 8'h39;
  localparam logic [7:0] ChLowA  = 8'h61;
  localparam logic [7:0] ChLowF  = 8'h66;
  localparam logic [7:0] ChUpA   = 8'h41;
  localparam logic [7:0] ChUpF   = 8'h46;

  // Limits of the two address forms.
  localparam logic [9:0] MaxOctet      = 10'd255;
  localparam logic [2:0] DottedGroups  = 3'd4;
  localparam logic [3:0] HexGroups     = 4'd8;
  localparam logic [2:0] MaxDecDigits  = 3'd3;
  localparam logic [2:0] MaxHexDigits  = 3'd4;
  localparam logic [2:0] LenSat        = 3'd5;
  localparam logic [2:0] DottedSat     = 3'd7;
  localparam logic [3:0] HexSat        = 4'd15;

  typedef enum logic [1:0] {
    VerdictNone = 2'd0,
    VerdictIpv4 = 2'd1,
    VerdictIpv6 = 2'd2
  } verdict_e;

  typedef struct packed {
    logic       saw_dot;
    logic       saw_colon;
    logic       dotted_fail;
    logic       hex_fail;
    logic [2:0] dotted_groups;
    logic [3:0] hex_groups;
    logic [2:0] group_length;
    logic [9:0] group_value;
    logic       leading_zero;
  } scan_state_t;

  // Result handed from the scanner to the output register.
  typedef struct packed {
    logic     valid;
    verdict_e verdict;
  } result_t;

endpackage

`default_nettype wire

@@ src/ipv_if.sv @@
// Channel interfaces of the address text validator: the character
// stream in and the verdict stream out.
// No dependencies.
`default_nettype none

interface ipv_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       has_char;
  logic       last;

  modport source (output valid, ch, has_char, last, input ready);
  modport sink (input valid, ch, has_char, last, output ready);
endinterface

interface ipv_verdict_if;
  logic       valid;
  logic       ready;
  logic [1:0] verdict;

  modport source (output valid, verdict, input ready);
  modport sink (input valid, verdict, output ready);
endinterface

`default_nettype wire

@@ src/ipv_scan.sv @@
// Input register and the per-character update of both address checkers.
// Depends on ipv_pkg.
`default_nettype none

module ipv_scan (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [7:0]     ch_i,
  input  wire logic           has_char_i,
  input  wire logic           last_i,
  output ipv_pkg::result_t    res_o,
  input  wire logic           res_ready_i
);

  logic                 in_valid_q;
  logic [7:0]           ch_q;
  logic                 has_char_q;
  logic                 last_q;
  logic                 advance;
  ipv_pkg::scan_state_t st_q, st_d, s1;
  logic                 is_dig, is_hex;
  logic                 dotted_bad, hex_bad;
  logic [2:0]           dg_fin;
  logic [3:0]           hg_fin;
  logic                 dfail_fin, hfail_fin;
  logic [9:0]           value_x10;

  // A transaction that ends a string needs room in the output register.
  assign advance    = in_valid_q && (!last_q || res_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ch_q       <= ch_i;
      has_char_q <= has_char_i;
      last_q     <= last_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign is_dig = (ch_q >= ipv_pkg::ChZero) && (ch_q <= ipv_pkg::ChNine);
  assign is_hex = is_dig ||
                  ((ch_q >= ipv_pkg::ChLowA) && (ch_q <= ipv_pkg::ChLowF)) ||
                  ((ch_q >= ipv_pkg::ChUpA) && (ch_q <= ipv_pkg::ChUpF));
  assign value_x10 = {st_q.group_value[6:0], 3'b000} + {st_q.group_value[8:0], 1'b0};

  // Group close checks, used both on a delimiter and at the end of the string.
  function automatic logic dotted_group_bad(input ipv_pkg::scan_state_t s);
    dotted_group_bad = (s.group_length == 3'd0) ||
                       (s.group_length > ipv_pkg::MaxDecDigits) ||
                       (s.leading_zero && (s.group_length > 3'd1)) ||
                       (s.group_value > ipv_pkg::MaxOctet);
  endfunction

  function automatic logic hex_group_bad(input ipv_pkg::scan_state_t s);
    hex_group_bad = (s.group_length == 3'd0) ||
                    (s.group_length > ipv_pkg::MaxHexDigits);
  endfunction

  always_comb begin
    s1 = st_q;
    dotted_bad = dotted_group_bad(st_q);
    hex_bad    = hex_group_bad(st_q);
    if (has_char_q) begin
      if (ch_q == ipv_pkg::ChDot) begin
        s1.saw_dot     = 1'b1;
        s1.hex_fail    = 1'b1;
        s1.dotted_fail = st_q.dotted_fail || dotted_bad;
        if (st_q.dotted_groups < ipv_pkg::DottedSat) begin
          s1.dotted_groups = st_q.dotted_groups + 3'd1;
        end
        s1.group_length = 3'd0;
        s1.group_value  = 10'd0;
        s1.leading_zero = 1'b0;
      end else if (ch_q == ipv_pkg::ChColon) begin
        s1.saw_colon   = 1'b1;
        s1.dotted_fail = 1'b1;
        s1.hex_fail    = st_q.hex_fail || hex_bad;
        if (st_q.hex_groups < ipv_pkg::HexSat) begin
          s1.hex_groups = st_q.hex_groups + 4'd1;
        end
        s1.group_length = 3'd0;
        s1.group_value  = 10'd0;
        s1.leading_zero = 1'b0;
      end else begin
        if (!is_dig) begin
          s1.dotted_fail = 1'b1;
        end
        if (!is_hex) begin
          s1.hex_fail = 1'b1;
        end
        if (st_q.group_length == 3'd0) begin
          s1.leading_zero = (ch_q == ipv_pkg::ChZero);
        end
        // Only the first three digits enter the value; later ones fail on length.
        if (is_dig && (st_q.group_length < ipv_pkg::MaxDecDigits)) begin
          s1.group_value = value_x10 + {6'd0, ch_q[3:0]};
        end
        if (st_q.group_length < ipv_pkg::LenSat) begin
          s1.group_length = st_q.group_length + 3'd1;
        end
      end
    end

    // The end of the string closes the open group in both checkers.
    dfail_fin = s1.dotted_fail || dotted_group_bad(s1);
    hfail_fin = s1.hex_fail || hex_group_bad(s1);
    dg_fin    = (s1.dotted_groups < ipv_pkg::DottedSat) ? s1.dotted_groups + 3'd1
                                                        : s1.dotted_groups;
    hg_fin    = (s1.hex_groups < ipv_pkg::HexSat) ? s1.hex_groups + 4'd1
                                                  : s1.hex_groups;

    res_o.valid   = in_valid_q && last_q;
    res_o.verdict = ipv_pkg::VerdictNone;
    if (s1.saw_dot) begin
      if (!dfail_fin && (dg_fin == ipv_pkg::DottedGroups)) begin
        res_o.verdict = ipv_pkg::VerdictIpv4;
      end
    end else if (s1.saw_colon) begin
      if (!hfail_fin && (hg_fin == ipv_pkg::HexGroups)) begin
        res_o.verdict = ipv_pkg::VerdictIpv6;
      end
    end

    if (!advance) begin
      st_d = st_q;
    end else if (last_q) begin
      st_d = '0;
    end else begin
      st_d = s1;
    end
  end

endmodule

`default_nettype wire

@@ src/ipv_out.sv @@
// Result register of the address text validator; holds a verdict until
// the receiver takes it.
// Depends on ipv_pkg.
`default_nettype none

module ipv_out (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire ipv_pkg::result_t  res_i,
  output logic                   res_ready_o,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic [1:0]             verdict_o
);

  logic             out_valid_q;
  ipv_pkg::verdict_e verdict_q;

  assign res_ready_o = !out_valid_q || out_ready_i;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_i.valid) begin
      verdict_q <= res_i.verdict;
    end
  end

endmodule

`default_nettype wire

@@ src/ip_address_text_validator.sv @@
// Address text validator: checks a character stream for a dotted IPv4 or
// a colon-separated IPv6 address. Depends on ipv_pkg, ipv_if, ipv_scan
// and ipv_out.
//
// Use: send the string one character per transaction on char_i, with last
// set on the final one. has_char = 0 carries no character; with last it ends
// the string (an empty string gives neither), without last it is dropped.
// One transaction on verdict_o follows each string: 0 neither, 1 IPv4,
// 2 IPv6. A dot anywhere makes the dotted rules decide; otherwise a colon
// makes the hex rules decide; with neither delimiter the verdict is neither.
// Throughput: one character per cycle, unless a string end waits for room
// in the result register. A verdict passes the input register, which takes
// its last character, and then the result register. If the receiver
// stalls, the result register holds the verdict and the input register
// holds one more character; characters that do not end a string keep
// flowing, and the string end after it waits.
// Reset clears the valid flags of both registers and all checker state;
// the block is ready straight out of reset.
`default_nettype none

module ip_address_text_validator (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  ipv_char_if.sink       char_i,
  ipv_verdict_if.source  verdict_o
);

  ipv_pkg::result_t res;
  logic             res_ready;

  ipv_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (char_i.valid),
    .in_ready_o  (char_i.ready),
    .ch_i        (char_i.ch),
    .has_char_i  (char_i.has_char),
    .last_i      (char_i.last),
    .res_o       (res),
    .res_ready_i (res_ready)
  );

  ipv_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (verdict_o.valid),
    .out_ready_i (verdict_o.ready),
    .verdict_o   (verdict_o.verdict)
  );

endmodule

`default_nettype wire

@@ verif/ipv_verdict_checker.sv @@
`timescale 1ns / 1ps
// Verdict checker for the address text validator: watches the character and
// verdict channels, predicts the verdict of every string and compares.
// Depends on ipv_pkg.
module ipv_verdict_checker
  import ipv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       char_valid_i,
  input  logic       char_ready_i,
  input  logic [7:0] char_ch_i,
  input  logic       char_has_char_i,
  input  logic       char_last_i,
  input  logic       verdict_valid_i,
  input  logic       verdict_ready_i,
  input  logic [1:0] verdict_i,
  output int         fail_count_o,
  output int         pending_o,
  output int         none_count_o,
  output int         ipv4_count_o,
  output int         ipv6_count_o
);

  scan_state_t scan;
  verdict_e    expected_verdicts[$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] verdict mismatch: %s", $time, msg);
    fail_count_o++;
  endtask

  function automatic void clear_group();
    scan.group_length = '0;
    scan.group_value  = '0;
    scan.leading_zero = 1'b0;
  endfunction

  function automatic void close_dotted();
    if (scan.group_length == 3'd0 || scan.group_length > MaxDecDigits ||
        (scan.leading_zero && scan.group_length > 3'd1) || scan.group_value > MaxOctet) begin
      scan.dotted_fail = 1'b1;
    end
    if (scan.dotted_groups < DottedSat) begin
      scan.dotted_groups = scan.dotted_groups + 3'd1;
    end
  endfunction

  function automatic void close_hex();
    if (scan.group_length == 3'd0 || scan.group_length > MaxHexDigits) begin
      scan.hex_fail = 1'b1;
    end
    if (scan.hex_groups < HexSat) begin
      scan.hex_groups = scan.hex_groups + 4'd1;
    end
  endfunction

  function automatic void scan_char(input logic [7:0] c);
    logic is_dig;
    logic is_hex;
    is_dig = (c >= ChZero && c <= ChNine);
    is_hex = is_dig || (c >= ChLowA && c <= ChLowF) || (c >= ChUpA && c <= ChUpF);
    if (c == ChDot) begin
      scan.saw_dot  = 1'b1;
      scan.hex_fail = 1'b1;
      close_dotted();
      clear_group();
    end else if (c == ChColon) begin
      scan.saw_colon   = 1'b1;
      scan.dotted_fail = 1'b1;
      close_hex();
      clear_group();
    end else begin
      if (!is_dig) scan.dotted_fail = 1'b1;
      if (!is_hex) scan.hex_fail = 1'b1;
      if (scan.group_length == 3'd0) scan.leading_zero = (c == ChZero);
      // Only the first three digits of a group build its value.
      if (is_dig && scan.group_length < MaxDecDigits) begin
        scan.group_value = scan.group_value * 10'd10 + {2'b00, c - ChZero};
      end
      if (scan.group_length < LenSat) scan.group_length = scan.group_length + 3'd1;
    end
  endfunction

  function automatic verdict_e string_verdict();
    verdict_e v;
    v = VerdictNone;
    if (scan.saw_dot) begin
      if (!scan.dotted_fail && scan.dotted_groups == DottedGroups) v = VerdictIpv4;
    end else if (scan.saw_colon) begin
      if (!scan.hex_fail && scan.hex_groups == HexGroups) v = VerdictIpv6;
    end
    return v;
  endfunction

  task automatic check_verdict(input logic [1:0] got);
    verdict_e want;
    if (expected_verdicts.size() == 0) begin
      report_mismatch($sformatf("verdict %0d arrived with no string pending", got));
    end else begin
      want = expected_verdicts.pop_front();
      if (got !== want) begin
        report_mismatch($sformatf("verdict %0d, expected %0d (%s)", got, want, want.name()));
      end
      case (want)
        VerdictIpv4: ipv4_count_o++;
        VerdictIpv6: ipv6_count_o++;
        default:     none_count_o++;
      endcase
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan = '0;
      expected_verdicts.delete();
    end else begin
      if (verdict_valid_i && verdict_ready_i) check_verdict(verdict_i);
      if (char_valid_i && char_ready_i) begin
        if (char_has_char_i) scan_char(char_ch_i);
        // Closing the open group on both sides mirrors how the block ends a string.
        if (char_last_i) begin
          close_dotted();
          close_hex();
          expected_verdicts.insert(expected_verdicts.size(), string_verdict());
          scan = '0;
        end
      end
    end
    pending_o = expected_verdicts.size();
  end

endmodule

@@ verif/tb_ip_address_text_validator.sv @@
`timescale 1ns / 1ps
// Top of the address text validator testbench: clock, reset, character and
// verdict traffic, a watchdog and the final verdict.
// Depends on ipv_pkg, ipv_if, ip_address_text_validator and ipv_verdict_checker.
module tb_ip_address_text_validator;
  import ipv_pkg::*;

  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 2000;
  localparam int RandomItems   = 600;
  localparam int MinStrings    = 36;
  localparam int QuietPart     = 480;

  logic       clk;
  logic       rst_n;
  bit         idle_on;
  bit         hold_off_req;
  int         items_sent;
  int         strings_sent;
  int         fail_count;
  int         pending;
  int         none_count;
  int         ipv4_count;
  int         ipv6_count;
  logic [7:0] text_q[$];
  string      directed_list[7] = '{".", "::", "0.", "F:", ".:", "9", "0.0.0.0"};

  ipv_char_if    char_bus ();
  ipv_verdict_if verdict_bus ();

  ip_address_text_validator i_dut (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .char_i    (char_bus),
    .verdict_o (verdict_bus)
  );

  ipv_verdict_checker i_verdict_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .char_valid_i    (char_bus.valid),
    .char_ready_i    (char_bus.ready),
    .char_ch_i       (char_bus.ch),
    .char_has_char_i (char_bus.has_char),
    .char_last_i     (char_bus.last),
    .verdict_valid_i (verdict_bus.valid),
    .verdict_ready_i (verdict_bus.ready),
    .verdict_i       (verdict_bus.verdict),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .none_count_o    (none_count),
    .ipv4_count_o    (ipv4_count),
    .ipv6_count_o    (ipv6_count)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one transaction from a falling edge and returns at the falling edge
  // after it was taken.
  task automatic send_item(input logic [7:0] c, input logic has, input logic lst);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      char_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    char_bus.valid    <= 1'b1;
    char_bus.ch       <= c;
    char_bus.has_char <= has;
    char_bus.last     <= lst;
    do @(posedge clk); while (!char_bus.ready);
    @(negedge clk);
    if (has || lst) items_sent++;
  endtask

  task automatic send_text(input bit random_end);
    bit end_item;
    end_item = (text_q.size() == 0) || (random_end && $urandom_range(0, 4) == 0);
    foreach (text_q[k]) begin
      if (random_end && $urandom_range(0, 9) == 0) begin
        send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      send_item(text_q[k], 1'b1, !end_item && k == text_q.size() - 1);
    end
    if (end_item) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    strings_sent++;
  endtask

  // Appends one character at the end of the string under construction.
  task automatic add_char(input logic [7:0] c);
    text_q.insert(text_q.size(), c);
  endtask

  task automatic add_number(input int unsigned v);
    string digits;
    digits = $sformatf("%0d", v);
    for (int k = 0; k < digits.len(); k++) add_char(digits[k]);
  endtask

  task automatic add_octet(input bit broken);
    if (!broken) begin
      add_number($urandom_range(0, 255));
    end else begin
      case ($urandom_range(0, 3))
        0: add_number($urandom_range(256, 999));
        1: begin
          add_char(ChZero);
          add_number($urandom_range(0, 99));
        end
        2: add_number($urandom_range(1000, 99999));
        default: ;
      endcase
    end
  endtask

  task automatic add_hex_group(input int len);
    int d;
    for (int k = 0; k < len; k++) begin
      d = $urandom_range(0, 15);
      if (d < 10) add_char(8'(ChZero + d));
      else if ($urandom_range(0, 1)) add_char(8'(ChLowA + d - 10));
      else add_char(8'(ChUpA + d - 10));
    end
  endtask

  task automatic build_dotted(input bit broken);
    int groups;
    groups = (broken && $urandom_range(0, 1)) ? $urandom_range(1, 9) : int'(DottedGroups);
    for (int g = 0; g < groups; g++) begin
      if (g > 0) add_char(ChDot);
      add_octet(broken && $urandom_range(0, 3) == 0);
    end
  endtask

  task automatic build_hex(input bit broken);
    int groups;
    int len;
    groups = (broken && $urandom_range(0, 1)) ? $urandom_range(1, 17) : int'(HexGroups);
    for (int g = 0; g < groups; g++) begin
      if (g > 0) add_char(ChColon);
      len = (broken && $urandom_range(0, 3) == 0) ? $urandom_range(0, 6)
                                                  : $urandom_range(1, int'(MaxHexDigits));
      add_hex_group(len);
    end
  endtask

  task automatic build_noise();
    repeat ($urandom_range(0, 6)) begin
      case ($urandom_range(0, 3))
        0: add_char(ChDot);
        1: add_char(ChColon);
        2: add_char(8'(ChZero + $urandom_range(0, 9)));
        default: add_char(8'($urandom_range(0, 255)));
      endcase
    end
  endtask

  task automatic mutate_text();
    int pos;
    if (text_q.size() > 0) begin
      pos = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 2))
        0: text_q[pos] = 8'($urandom_range(0, 255));
        1: text_q.delete(pos);
        default: text_q.insert(pos, $urandom_range(0, 1) ? ChDot : ChColon);
      endcase
    end
  endtask

  // Verdict receiver. A hold-off request keeps ready low long enough for the
  // block to back up into the character channel.
  initial begin : verdict_receiver
    verdict_bus.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        verdict_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        verdict_bus.ready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        verdict_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        verdict_bus.ready <= 1'b1;
      end else begin
        verdict_bus.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((char_bus.valid && char_bus.ready) || (verdict_bus.valid && verdict_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("Watchdog: no transaction for %0d cycles, %0d verdicts outstanding",
             WatchdogLimit, pending);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : stimulus
    bit hold_done;
    hold_done         = 1'b0;
    char_bus.valid    = 1'b0;
    char_bus.ch       = 8'h00;
    char_bus.has_char = 1'b0;
    char_bus.last     = 1'b0;
    rst_n             = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed strings: dropped item, empty string, non-ASCII character,
    // lone and doubled delimiters, trailing delimiters, mixed delimiters,
    // no delimiter and the smallest dotted address.
    idle_on = 1'b1;
    send_item(8'hff, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    foreach (directed_list[i]) begin
      text_q.delete();
      for (int k = 0; k < directed_list[i].len(); k++) add_char(directed_list[i][k]);
      send_text(1'b0);
    end

    while (items_sent < RandomItems || strings_sent < MinStrings) begin
      if (!hold_done && items_sent >= 150) begin
        hold_off_req = 1'b1;
        hold_done    = 1'b1;
      end
      idle_on = (items_sent < QuietPart) && ($urandom_range(0, 3) != 0);
      text_q.delete();
      case ($urandom_range(0, 9))
        0, 1, 2: build_dotted(1'b0);
        3, 4, 5: build_hex(1'b0);
        6: build_dotted(1'b1);
        7: build_hex(1'b1);
        8: build_noise();
        default: begin
          if ($urandom_range(0, 1)) build_dotted(1'b0);
          else build_hex(1'b0);
          mutate_text();
        end
      endcase
      send_text(1'b1);
    end

    char_bus.valid <= 1'b0;
    idle_on = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);

    $display("Sent %0d strings in %0d transactions, with one long verdict hold-off.",
             strings_sent, items_sent);
    $display("Verdicts checked: %0d IPv4, %0d IPv6, %0d neither; %0d mismatches.",
             ipv4_count, ipv6_count, none_count, fail_count);
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
